@@ rtl/core/pnd_pkg.sv @@
// Shared types and constants for the polyline nearest distance block.
`timescale 1ns / 1ps
package pnd_pkg;

  localparam int T_FRAC_BITS_DEF = 16;
  localparam int SCALE_FRAC_BITS = 24;

  localparam int LON_W     = 32;
  localparam int LAT_W     = 31;
  localparam int SCALE_W   = 24;
  localparam int DIST_W    = 48;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;

  localparam int DIFF_W   = 33;            // signed coordinate difference
  localparam int MAG_W    = 32;            // magnitude of a difference
  localparam int SCALED_W = MAG_W + SCALE_W;
  localparam int HALF_W   = SCALED_W / 2;
  localparam int MUL_W    = 32;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int LEN_W    = 2 * SCALED_W + 1;
  localparam int ACC_W    = LEN_W + 2;

  localparam int LEN_SHIFT    = 2 * SCALE_FRAC_BITS - 32;
  localparam int DIST_SHIFT   = 2 * SCALE_FRAC_BITS - 16;
  localparam int ZERO_LEN_Q32 = 4295;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [DIST_W-1:0]  DIST_MAX      = '1;
  localparam logic [SCALE_W-1:0] LON_GAIN_RST  = 24'd116053;
  localparam logic [SCALE_W-1:0] LAT_GAIN_RST  = 24'd186764;
  localparam logic [DIST_W-1:0]  RADIUS_SQ_RST = 48'd80281600;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUERY_LON = 3'd0,
    REG_QUERY_LAT = 3'd1,
    REG_LON_GAIN  = 3'd2,
    REG_LAT_GAIN  = 3'd3,
    REG_RADIUS_SQ = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_SEG,
    CMD_POINT
  } cmd_kind_t;

  typedef struct packed {
    logic signed [LON_W-1:0] x1;
    logic signed [LAT_W-1:0] y1;
    logic signed [LON_W-1:0] x2;
    logic signed [LAT_W-1:0] y2;
    cmd_kind_t               kind;
    logic                    restart;
    logic                    last;
  } vtx_cmd_t;

  typedef struct packed {
    logic signed [LON_W-1:0] query_lon;
    logic signed [LAT_W-1:0] query_lat;
    logic [SCALE_W-1:0]      lon_gain;
    logic [SCALE_W-1:0]      lat_gain;
    logic [DIST_W-1:0]       radius_sq;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_LEN_MAC,
    ST_LEN_WAIT,
    ST_LEN_CHK,
    ST_DOT_MAC,
    ST_DOT_WAIT,
    ST_DOT_CHK,
    ST_DIV,
    ST_OFF,
    ST_OFF_WAIT,
    ST_FIN,
    ST_DIST_SC,
    ST_DIST_MAC,
    ST_DIST_WAIT,
    ST_DONE
  } back_state_t;

  typedef enum logic [2:0] {
    WB_NONE,
    WB_ADD,
    WB_SUB,
    WB_SCALE,
    WB_OFFX,
    WB_OFFY
  } wb_t;

endpackage

@@ rtl/core/pnd_front.sv @@
// Front end: accepts vertices, tracks the previous vertex and classifies each request.
`timescale 1ns / 1ps
module pnd_front import pnd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [LON_W-1:0] vertex_lon,
  input  logic signed [LAT_W-1:0] vertex_lat,
  input  logic                    first_vertex,
  input  logic                    last_vertex,
  input  logic                    q_full,
  output logic                    push,
  output vtx_cmd_t                cmd
);

  logic signed [LON_W-1:0] prev_lon;
  logic signed [LAT_W-1:0] prev_lat;
  logic                    have_prev;
  logic                    seg_ok;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;
  // a first mark drops any partial road
  assign seg_ok   = have_prev && !first_vertex;

  always_comb begin
    cmd.x1      = prev_lon;
    cmd.y1      = prev_lat;
    cmd.x2      = vertex_lon;
    cmd.y2      = vertex_lat;
    cmd.restart = first_vertex;
    cmd.last    = last_vertex;
    if (seg_ok) begin
      cmd.kind = CMD_SEG;
    end else if (last_vertex) begin
      cmd.kind = CMD_POINT;
    end else begin
      cmd.kind = CMD_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
    end else if (push) begin
      have_prev <= !last_vertex;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_lon <= '0;
      prev_lat <= '0;
    end else if (push) begin
      prev_lon <= vertex_lon;
      prev_lat <= vertex_lat;
    end
  end

endmodule

@@ rtl/core/pnd_queue.sv @@
// Short request queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps
module pnd_queue import pnd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  vtx_cmd_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     valid,
  output vtx_cmd_t pop_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  vtx_cmd_t         entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign valid    = (count != '0);
  assign pop_data = entries[rd_ptr];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

@@ rtl/core/pnd_back.sv @@
// Back end: segment distance sequencer around one shared 32x32 multiplier.
`timescale 1ns / 1ps
module pnd_back import pnd_pkg::*; #(
  parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              cmd_valid,
  input  vtx_cmd_t          cmd,
  output logic              cmd_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DIST_W-1:0] nearest_sq,
  output logic              within_radius
);

  localparam int TW    = T_FRAC_BITS + 1;
  localparam int K_MAX = (T_FRAC_BITS > 8) ? T_FRAC_BITS : 8;
  localparam int K_W   = $clog2(K_MAX);
  localparam logic [TW-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};
  localparam logic [PROD_W:0] T_HALF = (PROD_W + 1)'(1) << (T_FRAC_BITS - 1);

  back_state_t state, state_next;
  logic [K_W-1:0] k, k_next;

  // request context
  cmd_kind_t kind_r;
  logic      last_r;
  logic [DIFF_W-1:0] ax_s, ay_s;
  logic [MAG_W-1:0]  mag [4];      // |bx|, |by|, |ax|, |ay|
  logic [3:0]        neg;
  logic [SCALED_W-1:0] sc [4];     // scaled magnitudes, same order
  logic [LEN_W-1:0]  len, rem;
  logic [TW-1:0]     t;
  logic [MAG_W-1:0]  qx, qy, dmag_x, dmag_y;

  // multiplier and writeback
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;
  wb_t        iss_wb, wb;
  logic [1:0] iss_sh, wb_sh;
  logic [1:0] iss_idx, wb_idx;
  logic [ACC_W-1:0] acc, pp_sh;
  logic [PROD_W:0]  rnd;

  logic [SCALED_W-1:0] mac_x, mac_y;
  logic                dot_neg;
  logic                len_zero, dot_pos, dot_ge;
  logic [LEN_W:0]      r2;
  logic                div_ge;
  logic [ACC_W-1:0]    dist_full;
  logic [DIST_W-1:0]   dist_sat, new_min;
  logic [DIST_W-1:0]   running_min;
  logic                out_free;

  logic [DIFF_W-1:0] x1e, x2e, qxe, y1e, y2e, qye, bx_d, by_d, ax_d, ay_d;
  logic [DIFF_W:0]   offx_s, offy_s, dx_d, dy_d;

  function automatic logic [MAG_W-1:0] abs_mag(input logic [DIFF_W:0] v);
    logic [DIFF_W:0] n;
    n = v[DIFF_W] ? (~v + 1'b1) : v;
    return n[MAG_W-1:0];
  endfunction

  function automatic logic [MUL_W-1:0] half(input logic [SCALED_W-1:0] x, input logic hi);
    return hi ? MUL_W'(x[SCALED_W-1:HALF_W]) : MUL_W'(x[HALF_W-1:0]);
  endfunction

  // coordinate differences taken when a request is popped
  assign x1e  = {cmd.x1[LON_W-1], cmd.x1};
  assign x2e  = {cmd.x2[LON_W-1], cmd.x2};
  assign qxe  = {cfg.query_lon[LON_W-1], cfg.query_lon};
  assign y1e  = {{2{cmd.y1[LAT_W-1]}}, cmd.y1};
  assign y2e  = {{2{cmd.y2[LAT_W-1]}}, cmd.y2};
  assign qye  = {{2{cfg.query_lat[LAT_W-1]}}, cfg.query_lat};
  assign bx_d = x2e - x1e;
  assign by_d = y2e - y1e;
  assign ax_d = qxe - ((cmd.kind == CMD_POINT) ? x2e : x1e);
  assign ay_d = qye - ((cmd.kind == CMD_POINT) ? y2e : y1e);

  assign mac_x   = (state == ST_DOT_MAC) ? (k[2] ? sc[3] : sc[2]) : (k[2] ? sc[1] : sc[0]);
  assign mac_y   = k[2] ? sc[1] : sc[0];
  assign dot_neg = k[2] ? (neg[3] ^ neg[1]) : (neg[2] ^ neg[0]);

  assign len_zero = (acc[LEN_W-1:0] >> LEN_SHIFT) < LEN_W'(ZERO_LEN_Q32);
  assign dot_pos  = !acc[ACC_W-1] && (acc != '0);
  assign dot_ge   = acc[LEN_W-1:0] >= len;
  assign r2       = {rem, 1'b0};
  assign div_ge   = r2 >= {1'b0, len};

  assign offx_s = neg[0] ? -{2'b00, qx} : {2'b00, qx};
  assign offy_s = neg[1] ? -{2'b00, qy} : {2'b00, qy};
  assign dx_d   = {ax_s[DIFF_W-1], ax_s} - offx_s;
  assign dy_d   = {ay_s[DIFF_W-1], ay_s} - offy_s;

  assign dist_full = acc >> DIST_SHIFT;
  assign dist_sat  = (|dist_full[ACC_W-1:DIST_W]) ? DIST_MAX : dist_full[DIST_W-1:0];
  assign new_min   = (dist_sat < running_min) ? dist_sat : running_min;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    case (wb_sh)
      2'd1:    pp_sh = ACC_W'(prod) << HALF_W;
      2'd2:    pp_sh = ACC_W'(prod) << (2 * HALF_W);
      default: pp_sh = ACC_W'(prod);
    endcase
  end

  assign rnd = {1'b0, prod} + T_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    cmd_pop    = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    iss_wb     = WB_NONE;
    iss_sh     = '0;
    iss_idx    = '0;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          k_next  = '0;
          if (cmd.kind != CMD_NONE) begin
            state_next = ST_SCALE;
          end
        end
      end
      ST_SCALE: begin
        mul_a   = mag[k[1:0]];
        mul_b   = k[0] ? MUL_W'(cfg.lat_gain) : MUL_W'(cfg.lon_gain);
        iss_wb  = WB_SCALE;
        iss_idx = k[1:0];
        if (k[1:0] == 2'd3) begin
          k_next     = '0;
          state_next = (kind_r == CMD_POINT) ? ST_OFF : ST_LEN_MAC;
        end else begin
          k_next = k + 1'b1;
        end
      end
      ST_LEN_MAC, ST_DOT_MAC, ST_DIST_MAC: begin
        mul_a  = half(mac_x, k[1]);
        mul_b  = half(mac_y, k[0]);
        iss_wb = ((state == ST_DOT_MAC) && dot_neg) ? WB_SUB : WB_ADD;
        iss_sh = {1'b0, k[1]} + {1'b0, k[0]};
        if (k[2:0] == 3'd7) begin
          k_next = '0;
          if (state == ST_LEN_MAC) begin
            state_next = ST_LEN_WAIT;
          end else if (state == ST_DOT_MAC) begin
            state_next = ST_DOT_WAIT;
          end else begin
            state_next = ST_DIST_WAIT;
          end
        end else begin
          k_next = k + 1'b1;
        end
      end
      ST_LEN_WAIT: state_next = ST_LEN_CHK;
      ST_LEN_CHK:  state_next = len_zero ? ST_OFF : ST_DOT_MAC;
      ST_DOT_WAIT: state_next = ST_DOT_CHK;
      ST_DOT_CHK: begin
        state_next = (dot_pos && !dot_ge) ? ST_DIV : ST_OFF;
      end
      ST_DIV: begin
        if (k == K_W'(T_FRAC_BITS - 1)) begin
          k_next     = '0;
          state_next = ST_OFF;
        end else begin
          k_next = k + 1'b1;
        end
      end
      ST_OFF: begin
        mul_a  = k[0] ? mag[1] : mag[0];
        mul_b  = MUL_W'(t);
        iss_wb = k[0] ? WB_OFFY : WB_OFFX;
        if (k[0]) begin
          k_next     = '0;
          state_next = ST_OFF_WAIT;
        end else begin
          k_next = k + 1'b1;
        end
      end
      ST_OFF_WAIT: state_next = ST_FIN;
      ST_FIN:      state_next = ST_DIST_SC;
      ST_DIST_SC: begin
        mul_a   = k[0] ? dmag_y : dmag_x;
        mul_b   = k[0] ? MUL_W'(cfg.lat_gain) : MUL_W'(cfg.lon_gain);
        iss_wb  = WB_SCALE;
        iss_idx = {1'b0, k[0]};
        if (k[0]) begin
          k_next     = '0;
          state_next = ST_DIST_MAC;
        end else begin
          k_next = k + 1'b1;
        end
      end
      ST_DIST_WAIT: state_next = ST_DONE;
      ST_DONE: begin
        if (!last_r || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers: writeback tag, accumulator, running minimum, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      wb          <= WB_NONE;
      acc         <= '0;
      running_min <= DIST_MAX;
      out_valid   <= 1'b0;
    end else begin
      wb <= iss_wb;
      case (wb)
        WB_ADD:  acc <= acc + pp_sh;
        WB_SUB:  acc <= acc - pp_sh;
        default: ;
      endcase
      if (state == ST_LEN_CHK || state == ST_DOT_CHK ||
          (state == ST_DONE && state_next == ST_IDLE)) begin
        acc <= '0;
      end
      if (state == ST_IDLE && cmd_pop && cmd.restart) begin
        running_min <= DIST_MAX;
      end
      if (state == ST_DONE) begin
        if (!last_r) begin
          running_min <= new_min;
        end else if (out_free) begin
          running_min <= DIST_MAX;
        end
      end
      if (state == ST_DONE && last_r && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath payload
  always_ff @(posedge clk) begin
    prod   <= mul_a * mul_b;
    wb_sh  <= iss_sh;
    wb_idx <= iss_idx;
    case (wb)
      WB_SCALE: sc[wb_idx] <= prod[SCALED_W-1:0];
      WB_OFFX:  qx <= rnd[T_FRAC_BITS +: MAG_W];
      WB_OFFY:  qy <= rnd[T_FRAC_BITS +: MAG_W];
      default:  ;
    endcase
    if (state == ST_IDLE && cmd_pop) begin
      kind_r <= cmd.kind;
      last_r <= cmd.last;
      ax_s   <= ax_d;
      ay_s   <= ay_d;
      mag[0] <= abs_mag({bx_d[DIFF_W-1], bx_d});
      mag[1] <= abs_mag({by_d[DIFF_W-1], by_d});
      mag[2] <= abs_mag({ax_d[DIFF_W-1], ax_d});
      mag[3] <= abs_mag({ay_d[DIFF_W-1], ay_d});
      neg    <= {ay_d[DIFF_W-1], ax_d[DIFF_W-1], by_d[DIFF_W-1], bx_d[DIFF_W-1]};
    end
    if (state == ST_SCALE && k[1:0] == 2'd3 && kind_r == CMD_POINT) begin
      t <= '0;
    end
    if (state == ST_LEN_CHK) begin
      len <= acc[LEN_W-1:0];
      t   <= '0;
    end
    if (state == ST_DOT_CHK) begin
      rem <= acc[LEN_W-1:0];
      t   <= (dot_pos && dot_ge) ? T_ONE : '0;
    end
    if (state == ST_DIV) begin
      rem <= div_ge ? LEN_W'(r2 - {1'b0, len}) : r2[LEN_W-1:0];
      t   <= {t[TW-2:0], div_ge};
    end
    if (state == ST_FIN) begin
      dmag_x <= abs_mag(dx_d);
      dmag_y <= abs_mag(dy_d);
    end
    if (state == ST_DONE && last_r && out_free) begin
      nearest_sq    <= new_min;
      within_radius <= (new_min <= cfg.radius_sq);
    end
  end

  a_div_rem_below_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < len))
    else $error("division remainder not below segment length");

  a_mac_starts_clear: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_LEN_MAC || state == ST_DIST_MAC) && k == '0) |->
      (acc == '0 && wb != WB_ADD && wb != WB_SUB))
    else $error("accumulator not clear at start of a product sum");

  a_t_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) |-> (t <= T_ONE))
    else $error("projection parameter above one");

endmodule

@@ rtl/core/polyline_nearest_distance.sv @@
// Top level: configuration registers, front end, request queue and distance back end.
`timescale 1ns / 1ps
// Streams road vertices and reports, on each last vertex, the smallest squared
// metric distance (Q.16 square meters, saturating) from the query point to the
// road and a within-radius flag. The front end takes a vertex unless the queue
// is full and places a request in a two-entry queue; the back end runs all
// arithmetic on one shared 32x32 multiplier and starts a request only after the
// last: a segment projecting inside runs scale, length, dot, divide, offset and
// distance, a clamped one skips the divide, a zero-length one the dot too, a
// one-vertex road the length too, and a vertex that closes nothing all. The
// finished result sits in an output register while the next vertices are
// processed; a second result waits in the back end until the first is taken.
module polyline_nearest_distance import pnd_pkg::*; #(
  parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [LON_W-1:0] vertex_lon,
  input  logic signed [LAT_W-1:0] vertex_lat,
  input  logic                    first_vertex,
  input  logic                    last_vertex,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [DIST_W-1:0]       nearest_sq,
  output logic                    within_radius
);

  cfg_t     cfg;
  vtx_cmd_t push_cmd, pop_cmd;
  logic     push, q_full, pop, q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.query_lon <= '0;
      cfg.query_lat <= '0;
      cfg.lon_gain  <= LON_GAIN_RST;
      cfg.lat_gain  <= LAT_GAIN_RST;
      cfg.radius_sq <= RADIUS_SQ_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_QUERY_LON: cfg.query_lon <= cfg_data[LON_W-1:0];
        REG_QUERY_LAT: cfg.query_lat <= cfg_data[LAT_W-1:0];
        REG_LON_GAIN:  cfg.lon_gain  <= cfg_data[SCALE_W-1:0];
        REG_LAT_GAIN:  cfg.lat_gain  <= cfg_data[SCALE_W-1:0];
        REG_RADIUS_SQ: cfg.radius_sq <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  pnd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .vertex_lon   (vertex_lon),
    .vertex_lat   (vertex_lat),
    .first_vertex (first_vertex),
    .last_vertex  (last_vertex),
    .q_full       (q_full),
    .push         (push),
    .cmd          (push_cmd)
  );

  pnd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .valid     (q_valid),
    .pop_data  (pop_cmd)
  );

  pnd_back #(
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd_valid     (q_valid),
    .cmd           (pop_cmd),
    .cmd_pop       (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .nearest_sq    (nearest_sq),
    .within_radius (within_radius)
  );

endmodule
